// ===== hdl/lbam_pkg.sv =====
package lbam_pkg;

  // Greyscale depth and lamp count
  localparam int GREY_BITS   = 4;
  localparam int LAMP_COUNT  = 64;
  localparam int BANK_LAMPS  = 8;
  localparam int BANK_COUNT  = LAMP_COUNT / BANK_LAMPS;
  localparam int CYCLE_TICKS = (1 << GREY_BITS) - 1;

  localparam int LAMP_W  = $clog2(LAMP_COUNT);
  localparam int BANK_W  = $clog2(BANK_COUNT);
  localparam int LANE_W  = $clog2(BANK_LAMPS);
  localparam int TICK_W  = 4;
  localparam int PLANE_W = 2;
  localparam int ROW_W   = BANK_LAMPS * GREY_BITS;

  localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(CYCLE_TICKS - 1);

  // Command codes carried in the input tuser field
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic load;    // load the output register
  } dp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained
  } dp_stat_t;

  // Plane shown at tick t: floor(log2(t+1))
  function automatic logic [PLANE_W-1:0] plane_of_tick(input logic [TICK_W-1:0] t);
    logic [TICK_W:0]      v;
    logic [PLANE_W-1:0]   p;
    v = {1'b0, t} + (TICK_W+1)'(1);
    p = '0;
    for (int i = 1; i <= TICK_W; i++) begin
      if ((v >> i) != '0) p = PLANE_W'(i);
    end
    return p;
  endfunction

endpackage

// ===== hdl/lbam_ctrl.sv =====
module lbam_ctrl
  import lbam_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  assign in_ready   = (state == ST_IDLE);
  assign ctl.accept = in_valid && in_ready;
  assign ctl.load   = (state == ST_EXEC) && stat.out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (ctl.accept) state_next = ST_EXEC;
      ST_EXEC: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== hdl/lbam_dp.sv =====
module lbam_dp
  import lbam_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_ctl_t            ctl,
  output dp_stat_t           stat,
  input  cmd_t               cmd_in,
  input  logic [LAMP_W-1:0]  lamp_in,
  input  logic [3:0]         level_in,
  input  logic [2:0]         bank_in,
  input  logic [TICK_W-1:0]  start_in,
  input  logic               start_we,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_bits,
  output logic [PLANE_W-1:0] out_plane,
  output logic [TICK_W-1:0]  out_tick
);

  logic [ROW_W-1:0]      mem [BANK_COUNT];
  logic [ROW_W-1:0]      rdata;
  logic [LAMP_COUNT-1:0] lamp_valid;
  logic [TICK_W-1:0]     start_position;
  logic [TICK_W-1:0]     tick;
  cmd_t                  cmd;
  logic [BANK_W-1:0]     bank;
  logic [PLANE_W-1:0]    plane;
  logic [7:0]            bits;

  logic [BANK_W-1:0] wr_row;
  logic [LANE_W-1:0] wr_lane;

  assign wr_row  = lamp_in[LAMP_W-1:LANE_W];
  assign wr_lane = lamp_in[LANE_W-1:0];

  assign stat.out_free = !out_valid || out_ready;

  // Start position register
  always_ff @(posedge clk) begin
    if (rst)           start_position <= '0;
    else if (start_we) start_position <= start_in;
  end

  // Level store: one row per bank, lane write; registered row read
  always_ff @(posedge clk) begin
    if (ctl.accept && cmd_in == CMD_WRITE) begin
      mem[wr_row][wr_lane*GREY_BITS +: GREY_BITS] <= level_in[GREY_BITS-1:0];
    end
    if (ctl.accept) rdata <= mem[bank_in[BANK_W-1:0]];
  end

  // Lamps never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_valid <= '0;
    end else if (ctl.accept && cmd_in == CMD_WRITE) begin
      lamp_valid[lamp_in] <= 1'b1;
    end
  end

  // Tick counter and captured command
  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (ctl.accept) begin
      case (cmd_in)
        CMD_TICK:    tick <= (tick == LAST_TICK) ? '0 : tick + TICK_W'(1);
        CMD_RESTART: tick <= (start_position > LAST_TICK) ? LAST_TICK : start_position;
        default:     tick <= tick;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd  <= cmd_in;
      bank <= bank_in[BANK_W-1:0];
    end
  end

  // Bank bits at the current plane
  assign plane = plane_of_tick(tick);

  always_comb begin
    for (int k = 0; k < BANK_LAMPS; k++) begin
      bits[k] = (cmd == CMD_READ) && lamp_valid[{bank, LANE_W'(k)}]
                && rdata[k*GREY_BITS + int'(plane)];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (ctl.load)     out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_bits  <= bits;
      out_plane <= plane;
      out_tick  <= tick;
    end
  end

endmodule

// ===== hdl/lamp_bit_angle_modulator.sv =====
// Each input transfer does a registered read of the level store, then loads the output
//   register once it is free; one result per item. No new item is taken until the
//   previous result has been loaded into the output register.
// Reset (rst, synchronous): levels read as zero, tick counter 0, start 0;
//   no clearing pass, items are taken the cycle after reset.
module lamp_bit_angle_modulator
  import lbam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration: start_position[3:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // lamp_index[5:0], level[9:6], bank_index[12:10], zero[15:13]
  input  logic [15:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // bank_bits[7:0], bit_plane[9:8], tick_position[13:10], zero[15:14]
  output logic [15:0] m_tdata
);

  dp_ctl_t            ctl;
  dp_stat_t           stat;
  logic [7:0]         out_bits;
  logic [PLANE_W-1:0] out_plane;
  logic [TICK_W-1:0]  out_tick;

  assign cfg_ready = 1'b1;

  lbam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  lbam_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .cmd_in    (cmd_t'(s_tuser)),
    .lamp_in   (s_tdata[5:0]),
    .level_in  (s_tdata[9:6]),
    .bank_in   (s_tdata[12:10]),
    .start_in  (cfg_data),
    .start_we  (cfg_valid && cfg_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bits  (out_bits),
    .out_plane (out_plane),
    .out_tick  (out_tick)
  );

  assign m_tdata = {2'b00, out_tick, out_plane, out_bits};

endmodule

// ===== sim/lamp_bit_angle_modulator_tb.sv =====
module lamp_bit_angle_modulator_tb;
  import lbam_pkg::*;

  // Expected result of one command, laid out as the low bits of m_tdata
  typedef struct packed {
    logic [TICK_W-1:0]  tick_position;
    logic [PLANE_W-1:0] bit_plane;
    logic [7:0]         bank_bits;
  } bank_view_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed plan: a command or a start position write
  typedef struct packed {
    row_kind_t          kind;
    cmd_t               cmd;
    logic [LAMP_W-1:0]  lamp;
    logic [3:0]         lvl;
    logic [BANK_W-1:0]  bank;
    logic [3:0]         start;
    logic               typed;
    bank_view_t         view;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // Predictor state
  logic [GREY_BITS-1:0] level_store [LAMP_COUNT];
  logic [TICK_W-1:0]    tick_now;
  logic [3:0]           start_reg;

  bank_view_t expected_views [$];
  int         mismatch_count = 0;
  bit         calm = 1'b0;   // no idling on either side
  int         stall_left = 0;
  bank_view_t want;

  plan_row_t  plan [PLAN_ROWS];

  lamp_bit_angle_modulator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Plane for a tick: count halvings of t+1 down to one
  function automatic logic [PLANE_W-1:0] plane_for(input logic [TICK_W-1:0] t);
    logic [TICK_W:0]    v;
    logic [PLANE_W-1:0] p;
    v = {1'b0, t} + 1'b1;
    p = '0;
    while (v > 1) begin
      v = v >> 1;
      p = p + 1'b1;
    end
    return p;
  endfunction

  // Apply one command to the predictor and return the lamp bank view
  function automatic bank_view_t apply_command(input cmd_t cmd,
                                               input logic [LAMP_W-1:0] lamp,
                                               input logic [3:0] lvl,
                                               input logic [BANK_W-1:0] bank);
    bank_view_t r;
    int         k;
    int         n;
    case (cmd)
      CMD_WRITE: begin
        if (int'(lamp) < LAMP_COUNT) level_store[lamp] = lvl[GREY_BITS-1:0];
      end
      CMD_TICK: begin
        tick_now = (tick_now == LAST_TICK) ? '0 : tick_now + 1'b1;
      end
      CMD_RESTART: begin
        tick_now = (start_reg > LAST_TICK) ? LAST_TICK : start_reg;
      end
      default: ;
    endcase
    r.tick_position = tick_now;
    r.bit_plane = plane_for(tick_now);
    r.bank_bits = '0;
    if (cmd == CMD_READ) begin
      for (k = 0; k < BANK_LAMPS; k++) begin
        n = int'(bank) * BANK_LAMPS + k;
        if (n < LAMP_COUNT) r.bank_bits[k] = level_store[n][r.bit_plane];
      end
    end
    return r;
  endfunction

  // Present one command and hold it until the transfer; queue its result
  task automatic send_command(input cmd_t cmd, input logic [LAMP_W-1:0] lamp,
                              input logic [3:0] lvl, input logic [BANK_W-1:0] bank,
                              input logic typed, input bank_view_t typed_view);
    bank_view_t got;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, bank, lvl, lamp};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    got = apply_command(cmd, lamp, lvl, bank);
    expected_views.push_back(typed ? typed_view : got);
  endtask

  // Random gap on the input side after a transfer
  task automatic sender_pause();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Start position write, only once every result has drained
  task automatic write_start(input logic [3:0] v);
    s_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_reg = v;
  endtask

  // Output side: ready with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_views.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata %h", m_tdata));
      end else begin
        want = expected_views.pop_front();
        if (m_tdata[7:0] != want.bank_bits)
          report_mismatch($sformatf("bank_bits %h, want %h", m_tdata[7:0], want.bank_bits));
        if (m_tdata[9:8] != want.bit_plane)
          report_mismatch($sformatf("bit_plane %0d, want %0d", m_tdata[9:8], want.bit_plane));
        if (m_tdata[13:10] != want.tick_position)
          report_mismatch($sformatf("tick_position %0d, want %0d", m_tdata[13:10],
                                    want.tick_position));
      end
    end
  end

  // Run limit
  initial begin
    #5000000;
    $display("lamp_bit_angle_modulator: mismatch");
    $finish;
  end

  initial begin
    cmd_t       cmd;
    int         pick;
    logic [3:0] phase_start;

    foreach (level_store[i]) level_store[i] = '0;
    tick_now  = '0;
    start_reg = '0;

    // Reset state, extremes, wrap and saturation of the start position
    plan = '{
      '{ROW_ITEM, CMD_READ,    6'd0,  4'd0,  3'd7, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h00}},
      '{ROW_ITEM, CMD_TICK,    6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd1,  2'd1, 8'h00}},
      '{ROW_ITEM, CMD_RESTART, 6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h00}},
      '{ROW_ITEM, CMD_WRITE,   6'd63, 4'd15, 3'd0, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h00}},
      '{ROW_ITEM, CMD_WRITE,   6'd0,  4'd15, 3'd0, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h00}},
      '{ROW_ITEM, CMD_WRITE,   6'd7,  4'd9,  3'd0, 4'd0,  1'b0, '0},
      '{ROW_ITEM, CMD_READ,    6'd0,  4'd0,  3'd7, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h80}},
      '{ROW_ITEM, CMD_READ,    6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h81}},
      '{ROW_CFG,  CMD_WRITE,   6'd0,  4'd0,  3'd0, 4'd15, 1'b0, '0},
      '{ROW_ITEM, CMD_RESTART, 6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd14, 2'd3, 8'h00}},
      '{ROW_ITEM, CMD_READ,    6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd14, 2'd3, 8'h81}},
      '{ROW_ITEM, CMD_READ,    6'd0,  4'd0,  3'd7, 4'd0,  1'b1, '{4'd14, 2'd3, 8'h80}},
      '{ROW_ITEM, CMD_TICK,    6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h00}},
      '{ROW_ITEM, CMD_WRITE,   6'd42, 4'd6,  3'd0, 4'd0,  1'b0, '0},
      '{ROW_ITEM, CMD_WRITE,   6'd5,  4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{ROW_CFG,  CMD_WRITE,   6'd0,  4'd0,  3'd0, 4'd3,  1'b0, '0},
      '{ROW_ITEM, CMD_RESTART, 6'd0,  4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{ROW_ITEM, CMD_READ,    6'd0,  4'd0,  3'd5, 4'd0,  1'b0, '0},
      '{ROW_ITEM, CMD_TICK,    6'd0,  4'd0,  3'd0, 4'd0,  1'b0, '0},
      '{ROW_CFG,  CMD_WRITE,   6'd0,  4'd0,  3'd0, 4'd14, 1'b0, '0},
      '{ROW_ITEM, CMD_RESTART, 6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd14, 2'd3, 8'h00}},
      '{ROW_ITEM, CMD_TICK,    6'd0,  4'd0,  3'd0, 4'd0,  1'b1, '{4'd0,  2'd0, 8'h00}},
      '{ROW_ITEM, CMD_WRITE,   6'd21, 4'd10, 3'd0, 4'd0,  1'b0, '0},
      '{ROW_ITEM, CMD_READ,    6'd0,  4'd0,  3'd2, 4'd0,  1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed plan
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_start(plan[r].start);
      end else begin
        send_command(plan[r].cmd, plan[r].lamp, plan[r].lvl, plan[r].bank,
                     plan[r].typed, plan[r].view);
        sender_pause();
      end
    end

    // Random phases, each under its own start position; phase 3 and the last run without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       phase_start = 4'd15;
        1:       phase_start = 4'd0;
        2:       phase_start = 4'd14;
        default: phase_start = 4'($urandom_range(0, 15));
      endcase
      write_start(phase_start);
      calm = (ph == 3) || (ph == PHASES - 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) cmd = CMD_WRITE;
        else if (pick < 68) cmd = CMD_TICK;
        else if (pick < 76) cmd = CMD_RESTART;
        else cmd = CMD_READ;
        send_command(cmd, 6'($urandom), 4'($urandom), 3'($urandom), 1'b0, '0);
        sender_pause();
      end
    end

    // Drain, then let the pipeline settle
    s_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lamp_bit_angle_modulator: match");
    end else begin
      $display("lamp_bit_angle_modulator: mismatch");
    end
    $finish;
  end

endmodule
